// ===== rtl/bcft_pkg.sv =====
// ----------------------------------------------------------------------------
// bcft_pkg
// Shared types and constants for the button countdown fan timer.
// ----------------------------------------------------------------------------
package bcft_pkg;

  localparam int DEBOUNCE_COUNT = 3;
  localparam int SEC_MAX        = 59;
  localparam int PRESET_MAX     = 10;
  localparam int PRESET_MIN     = 2;
  localparam int PRESET_STEP    = 2;
  localparam int COOL_MAX       = 60;
  localparam int COOL_MIN       = 30;
  localparam int COOL_PER_MIN   = 10;
  localparam int STOP_SEC_LIMIT = 50;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_PRESS  = 8'd0,
    REG_SHORT      = 8'd1,
    REG_LONG       = 8'd2,
    REG_SET_IDLE   = 8'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_STANDBY = 2'd0,
    ST_SETTING = 2'd1,
    ST_COOLING = 2'd2,
    ST_RUNNING = 2'd3
  } status_t;

  typedef struct packed {
    logic action;
    logic button_level;
  } item_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] min_press;
    logic [CFG_DATA_W-1:0] short_press;
    logic [CFG_DATA_W-1:0] long_press;
    logic [CFG_DATA_W-1:0] set_idle;
  } cfg_t;

  // Packed so that fan_on lands in bit 0.
  typedef struct packed {
    logic       timer_done;
    logic [5:0] cooling_left;
    logic [3:0] preset_minutes;
    logic [5:0] shown_seconds;
    logic [3:0] shown_minutes;
    status_t    status;
    logic       fan_on;
  } result_t;

endpackage

// ===== rtl/bcft_core.sv =====
// ----------------------------------------------------------------------------
// bcft_core
// Timer state and single-pass next-state logic: debounce, press timing,
// set mode, countdown and cooling. Result is formed from the next state.
// ----------------------------------------------------------------------------
module bcft_core #(
  parameter int TIME_BITS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  bcft_pkg::item_t  item,
  input  bcft_pkg::cfg_t   cfg,
  output bcft_pkg::result_t result
);
  import bcft_pkg::*;

  logic                 cand_r, cand_nxt;
  logic [1:0]           sc_r, sc_nxt;
  logic                 deb_r, deb_nxt;
  logic                 prev_r, prev_nxt;
  logic [TIME_BITS-1:0] tick_r, tick_nxt;
  logic [TIME_BITS-1:0] press_start_r, press_start_nxt;
  logic [TIME_BITS-1:0] set_start_r, set_start_nxt;
  logic                 pressed_r, pressed_nxt;
  logic                 released_r, released_nxt;
  logic                 lh_r, lh_nxt;
  logic                 set_mode_r, set_mode_nxt;
  logic [3:0]           preset_r, preset_nxt;
  logic                 running_r, running_nxt;
  logic                 cooling_r, cooling_nxt;
  logic [3:0]           min_r, min_nxt;
  logic [5:0]           sec_r, sec_nxt;
  logic [5:0]           cool_r, cool_nxt;
  logic                 fan_r, fan_nxt;

  logic                 stable;
  logic [TIME_BITS-1:0] dur, hold, idle;
  logic [4:0]           diff;
  logic [4:0]           preset_step;

  always_comb begin
    cand_nxt        = cand_r;
    sc_nxt          = sc_r;
    deb_nxt         = deb_r;
    prev_nxt        = prev_r;
    tick_nxt        = tick_r;
    press_start_nxt = press_start_r;
    set_start_nxt   = set_start_r;
    pressed_nxt     = pressed_r;
    released_nxt    = released_r;
    lh_nxt          = lh_r;
    set_mode_nxt    = set_mode_r;
    preset_nxt      = preset_r;
    running_nxt     = running_r;
    cooling_nxt     = cooling_r;
    min_nxt         = min_r;
    sec_nxt         = sec_r;
    cool_nxt        = cool_r;
    fan_nxt         = fan_r;
    stable          = 1'b0;
    dur             = '0;
    hold            = '0;
    idle            = '0;
    diff            = {1'b0, preset_r} - {1'b0, min_r};
    preset_step     = {1'b0, preset_r} + 5'(PRESET_STEP);

    if (!item.action) begin
      tick_nxt = tick_r + TIME_BITS'(1);
      if (item.button_level == cand_r) begin
        if (sc_r < 2'(DEBOUNCE_COUNT)) sc_nxt = sc_r + 2'd1;
        if (sc_nxt == 2'(DEBOUNCE_COUNT)) deb_nxt = cand_r;
      end else begin
        cand_nxt = item.button_level;
        sc_nxt   = 2'd1;
      end
      stable = (sc_nxt == 2'(DEBOUNCE_COUNT));

      if (stable && prev_r && !deb_nxt) begin
        press_start_nxt = tick_nxt;
        pressed_nxt     = 1'b1;
        released_nxt    = 1'b0;
      end

      if (stable && !prev_r && deb_nxt) begin
        dur          = tick_nxt - press_start_r;
        lh_nxt       = 1'b0;
        pressed_nxt  = 1'b0;
        released_nxt = 1'b1;
        if (dur >= TIME_BITS'(cfg.min_press)) begin
          if (!set_mode_r) begin
            if (dur < TIME_BITS'(cfg.short_press) && !cooling_r) begin
              // short click outside set mode and cooling: start, or stop with optional cooling
              running_nxt = !running_r;
              fan_nxt     = 1'b1;
              if (!running_r) begin
                min_nxt = preset_r;
                sec_nxt = 6'(SEC_MAX);
              end else if (diff != 5'd0 && sec_r <= 6'(STOP_SEC_LIMIT)) begin
                cooling_nxt = 1'b1;
                if (diff[4])                cool_nxt = 6'd0;
                else if (diff >= 5'd6)      cool_nxt = 6'(COOL_MAX);
                else                        cool_nxt = 6'(diff[2:0]) * 6'(COOL_PER_MIN);
              end else begin
                fan_nxt = 1'b0;
              end
            end
          end else if (dur < TIME_BITS'(cfg.short_press)) begin
            preset_nxt    = (preset_step > 5'(PRESET_MAX)) ? 4'(PRESET_MIN)
                                                           : preset_step[3:0];
            set_start_nxt = tick_nxt;
          end
        end
      end

      hold = tick_nxt - press_start_nxt;
      if (!lh_nxt && pressed_nxt && hold >= TIME_BITS'(cfg.long_press)) begin
        if (!set_mode_r && !running_nxt) begin
          lh_nxt        = 1'b1;
          set_mode_nxt  = 1'b1;
          set_start_nxt = tick_nxt;
        end else if (set_mode_r) begin
          lh_nxt       = 1'b1;
          set_mode_nxt = 1'b0;
        end
      end

      idle = tick_nxt - set_start_nxt;
      if (set_mode_nxt && released_nxt && idle >= TIME_BITS'(cfg.set_idle))
        set_mode_nxt = 1'b0;

      if (stable) prev_nxt = deb_nxt;
    end else begin
      if (running_r) begin
        if (sec_r != 6'd0) begin
          sec_nxt = sec_r - 6'd1;
        end else if (min_r != 4'd0) begin
          min_nxt = min_r - 4'd1;
          sec_nxt = 6'(SEC_MAX);
        end else begin
          running_nxt = 1'b0;
          cooling_nxt = 1'b1;
          if (preset_r < 4'd3)      cool_nxt = 6'(COOL_MIN);
          else if (preset_r > 4'd6) cool_nxt = 6'(COOL_MAX);
          else                      cool_nxt = 6'(preset_r) * 6'(COOL_PER_MIN);
        end
      end else if (cooling_r) begin
        if (cool_r <= 6'd1) begin
          cool_nxt    = 6'd0;
          cooling_nxt = 1'b0;
          fan_nxt     = 1'b0;
        end else begin
          cool_nxt = cool_r - 6'd1;
        end
      end
    end
  end

  always_comb begin
    result.fan_on         = fan_nxt;
    result.preset_minutes = preset_nxt;
    result.cooling_left   = cool_nxt;
    result.timer_done     = running_nxt && !cooling_nxt && min_nxt == 4'd0 && sec_nxt == 6'd0;
    if (set_mode_nxt)      result.status = ST_SETTING;
    else if (cooling_nxt)  result.status = ST_COOLING;
    else if (running_nxt)  result.status = ST_RUNNING;
    else                   result.status = ST_STANDBY;
    if (set_mode_nxt || (!running_nxt && !cooling_nxt)) begin
      result.shown_minutes = preset_nxt;
      result.shown_seconds = 6'd0;
    end else if (cooling_nxt) begin
      if (cool_nxt >= 6'(COOL_MAX)) begin
        result.shown_minutes = 4'd1;
        result.shown_seconds = cool_nxt - 6'(COOL_MAX);
      end else begin
        result.shown_minutes = 4'd0;
        result.shown_seconds = cool_nxt;
      end
    end else begin
      result.shown_minutes = min_nxt;
      result.shown_seconds = sec_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_r        <= 1'b1;
      sc_r          <= 2'd0;
      deb_r         <= 1'b1;
      prev_r        <= 1'b1;
      tick_r        <= '0;
      press_start_r <= '0;
      set_start_r   <= '0;
      pressed_r     <= 1'b0;
      released_r    <= 1'b0;
      lh_r          <= 1'b0;
      set_mode_r    <= 1'b0;
      preset_r      <= 4'(PRESET_MAX);
      running_r     <= 1'b0;
      cooling_r     <= 1'b0;
      min_r         <= 4'd0;
      sec_r         <= 6'd0;
      cool_r        <= 6'd0;
      fan_r         <= 1'b0;
    end else if (step) begin
      cand_r        <= cand_nxt;
      sc_r          <= sc_nxt;
      deb_r         <= deb_nxt;
      prev_r        <= prev_nxt;
      tick_r        <= tick_nxt;
      press_start_r <= press_start_nxt;
      set_start_r   <= set_start_nxt;
      pressed_r     <= pressed_nxt;
      released_r    <= released_nxt;
      lh_r          <= lh_nxt;
      set_mode_r    <= set_mode_nxt;
      preset_r      <= preset_nxt;
      running_r     <= running_nxt;
      cooling_r     <= cooling_nxt;
      min_r         <= min_nxt;
      sec_r         <= sec_nxt;
      cool_r        <= cool_nxt;
      fan_r         <= fan_nxt;
    end
  end

endmodule

// ===== rtl/button_countdown_fan_timer.sv =====
// ----------------------------------------------------------------------------
// button_countdown_fan_timer
// Debounced button control of a countdown timer with fan cooling period.
// An accepted beat waits in the input register; its result is registered
// into out_tdata. Throughput: one beat per cycle while out_tready is high;
// a beat is taken while a result waits only if the input register is empty.
// Reset: synchronous active-low; config registers return to their defaults.
// ----------------------------------------------------------------------------
module button_countdown_fan_timer #(
  parameter int TIME_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,   // [0] button_level
  input  logic [0:0]                       in_tuser,   // [0] action
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [0] fan_on, [2:1] status, [6:3] shown_minutes, [12:7] shown_seconds,
  // [16:13] preset_minutes, [22:17] cooling_left, [23] timer_done
  output logic [23:0]                      out_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bcft_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bcft_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import bcft_pkg::*;

  logic    in_valid_r;
  item_t   item_r;
  logic    out_valid_r;
  result_t out_r;
  cfg_t    cfg_r;
  result_t result;
  logic    advance;

  assign advance    = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !in_valid_r || advance;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;
  assign cfg_ready  = 1'b1;

  bcft_core #(.TIME_BITS(TIME_BITS)) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .item   (item_r),
    .cfg    (cfg_r),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) in_valid_r <= in_tvalid;
      if (advance)         out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.action       <= in_tuser[0];
      item_r.button_level <= in_tdata[0];
    end
    if (advance) out_r <= result;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_press   <= 16'd2;
      cfg_r.short_press <= 16'd100;
      cfg_r.long_press  <= 16'd150;
      cfg_r.set_idle    <= 16'd500;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MIN_PRESS: cfg_r.min_press   <= cfg_data;
        REG_SHORT:     cfg_r.short_press <= cfg_data;
        REG_LONG:      cfg_r.long_press  <= cfg_data;
        REG_SET_IDLE:  cfg_r.set_idle    <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/bcft_checker.sv =====
// ----------------------------------------------------------------------------
// bcft_checker
// Port-level checks on the fan timer result stream.
// ----------------------------------------------------------------------------
module bcft_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);
  import bcft_pkg::*;

  // stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat dropped or changed under stall");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_fan: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[2:1] == ST_COOLING || out_tdata[2:1] == ST_RUNNING)
      |-> out_tdata[0])
    else $error("fan off while running or cooling");

  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[23] |-> out_tdata[2:1] == ST_RUNNING
      && out_tdata[6:3] == 4'd0 && out_tdata[12:7] == 6'd0)
    else $error("timer_done outside a finished run");

  a_preset: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[13] && out_tdata[16:13] != 4'd0
      && out_tdata[16:13] <= 4'(PRESET_MAX))
    else $error("preset out of range");

endmodule

bind button_countdown_fan_timer bcft_checker u_bcft_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== test/tb_button_countdown_fan_timer.sv =====
// ----------------------------------------------------------------------------
// tb_button_countdown_fan_timer
// Self-checking testbench for the button countdown fan timer. A queue-fed
// driver sends button samples and one-second ticks with random gaps, a
// monitor stalls the result side at random and checks every result beat
// field by field against a cycle-free predictor of the timer. Timing
// registers are rewritten between phases, the extremes included.
// ----------------------------------------------------------------------------
module tb_button_countdown_fan_timer;
  import bcft_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam logic [CFG_IDX_W-1:0] SPARE_IDX = 8'd9;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata   = '0;   // [0] button_level
  logic [0:0]            in_tuser   = '0;   // [0] action
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // [0] fan_on, [2:1] status, [6:3] shown_minutes, [12:7] shown_seconds,
  // [16:13] preset_minutes, [22:17] cooling_left, [23] timer_done
  logic [23:0]           out_tdata;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  button_countdown_fan_timer i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  item_t   pending_beats[$];
  result_t expected_results[$];
  int      beats_queued = 0;
  int      results_seen = 0;
  int      err_count    = 0;
  int      cycle_count  = 0;
  int      in_gap       = 0;
  int      out_gap      = 0;
  bit      steady       = 1'b0;
  item_t   drive_item;
  result_t got_r, want_r;

  // timer state as the predictor sees it
  logic [CFG_DATA_W-1:0] min_cfg, short_cfg, long_cfg, idle_cfg;
  logic        pin_cand, pin_level, pin_prev;
  logic [1:0]  pin_cnt;
  logic [31:0] now_ticks, press_t0, set_t0;
  logic        held, released, long_done, in_set, counting, cooling_on, fan_q;
  logic [3:0]  preset_m, mins_q;
  logic [5:0]  secs_q;
  logic [6:0]  cool_q;

  initial forever #5 clk = ~clk;

  function automatic void reset_timer_model();
    min_cfg    = 16'd2;
    short_cfg  = 16'd100;
    long_cfg   = 16'd150;
    idle_cfg   = 16'd500;
    pin_cand   = 1'b1;
    pin_cnt    = 2'd0;
    pin_level  = 1'b1;
    pin_prev   = 1'b1;
    now_ticks  = '0;
    press_t0   = '0;
    set_t0     = '0;
    held       = 1'b0;
    released   = 1'b0;
    long_done  = 1'b0;
    in_set     = 1'b0;
    preset_m   = 4'(PRESET_MAX);
    counting   = 1'b0;
    cooling_on = 1'b0;
    mins_q     = '0;
    secs_q     = '0;
    cool_q     = '0;
    fan_q      = 1'b0;
  endfunction

  function automatic logic [31:0] ticks_since(logic [31:0] t0);
    return now_ticks - t0;
  endfunction

  // short click outside set mode: start, or stop with optional cooling
  function automatic void start_stop();
    int diff;
    counting = !counting;
    fan_q    = 1'b1;
    if (counting) begin
      mins_q = preset_m;
      secs_q = 6'(SEC_MAX);
    end else begin
      diff = int'(preset_m) - int'(mins_q);
      if (diff != 0 && secs_q <= STOP_SEC_LIMIT) begin
        diff = diff * COOL_PER_MIN;
        if (diff > COOL_MAX) diff = COOL_MAX;
        if (diff < 0) diff = 0;
        cooling_on = 1'b1;
        cool_q     = 7'(diff);
      end else begin
        fan_q = 1'b0;
      end
    end
  endfunction

  function automatic void button_sample(logic raw);
    logic        stable;
    logic [31:0] dur;
    now_ticks = now_ticks + 1;
    if (raw == pin_cand) begin
      if (pin_cnt < DEBOUNCE_COUNT) pin_cnt++;
      if (pin_cnt >= DEBOUNCE_COUNT) pin_level = pin_cand;
    end else begin
      pin_cand = raw;
      pin_cnt  = 2'd1;
    end
    stable = (pin_cnt >= DEBOUNCE_COUNT);

    if (stable && pin_prev && !pin_level) begin
      press_t0 = now_ticks;
      held     = 1'b1;
      released = 1'b0;
    end

    if (stable && !pin_prev && pin_level) begin
      dur       = ticks_since(press_t0);
      long_done = 1'b0;
      held      = 1'b0;
      released  = 1'b1;
      if (dur >= min_cfg) begin
        if (!in_set) begin
          if (dur < short_cfg && !cooling_on) start_stop();
        end else if (dur < short_cfg) begin
          preset_m = preset_m + 4'(PRESET_STEP);
          if (preset_m > PRESET_MAX) preset_m = 4'(PRESET_MIN);
          set_t0 = now_ticks;
        end
      end
    end

    if (!long_done && held && ticks_since(press_t0) >= long_cfg) begin
      if (!in_set && !counting) begin
        long_done = 1'b1;
        in_set    = 1'b1;
        set_t0    = now_ticks;
      end else if (in_set) begin
        long_done = 1'b1;
        in_set    = 1'b0;
      end
    end

    if (in_set && released && ticks_since(set_t0) >= idle_cfg) in_set = 1'b0;

    if (stable) pin_prev = pin_level;
  endfunction

  function automatic void second_elapsed();
    int c;
    if (counting) begin
      if (secs_q > 0) begin
        secs_q--;
      end else if (mins_q > 0) begin
        mins_q--;
        secs_q = 6'(SEC_MAX);
      end else begin
        c = int'(preset_m) * COOL_PER_MIN;
        if (c < COOL_MIN) c = COOL_MIN;
        else if (c > COOL_MAX) c = COOL_MAX;
        counting   = 1'b0;
        cooling_on = 1'b1;
        cool_q     = 7'(c);
      end
    end else if (cooling_on) begin
      if (cool_q <= 1) begin
        cool_q     = '0;
        cooling_on = 1'b0;
        fan_q      = 1'b0;
      end else begin
        cool_q--;
      end
    end
  endfunction

  function automatic result_t timer_next(item_t it);
    result_t r;
    if (!it.action) button_sample(it.button_level);
    else second_elapsed();

    if (in_set) r.status = ST_SETTING;
    else if (cooling_on) r.status = ST_COOLING;
    else if (counting) r.status = ST_RUNNING;
    else r.status = ST_STANDBY;

    if (in_set || (!counting && !cooling_on)) begin
      r.shown_minutes = preset_m;
      r.shown_seconds = '0;
    end else if (cooling_on) begin
      r.shown_minutes = 4'(cool_q / 60);
      r.shown_seconds = 6'(cool_q % 60);
    end else begin
      r.shown_minutes = mins_q;
      r.shown_seconds = secs_q;
    end

    r.fan_on         = fan_q;
    r.preset_minutes = preset_m;
    r.cooling_left   = cool_q[5:0];
    r.timer_done     = counting && !cooling_on && mins_q == 0 && secs_q == 0;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t: %s mismatch, got %0d expected %0d", $time, what, got, want);
    err_count++;
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) expected_results.push_back(timer_next(drive_item));
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_beats.size() != 0) begin
          drive_item = pending_beats.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {7'd0, drive_item.button_level};
          in_tuser  <= drive_item.action;
          if (!steady && $urandom_range(0, 9) == 0) in_gap = $urandom_range(1, 5);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        got_r = out_tdata;
        if (expected_results.size() == 0) begin
          report_mismatch("beat with nothing pending", int'(got_r), 0);
        end else begin
          want_r = expected_results.pop_front();
          if (got_r.fan_on != want_r.fan_on)
            report_mismatch("fan_on", got_r.fan_on, want_r.fan_on);
          if (got_r.status != want_r.status)
            report_mismatch("status", int'(got_r.status), int'(want_r.status));
          if (got_r.shown_minutes != want_r.shown_minutes)
            report_mismatch("shown_minutes", got_r.shown_minutes, want_r.shown_minutes);
          if (got_r.shown_seconds != want_r.shown_seconds)
            report_mismatch("shown_seconds", got_r.shown_seconds, want_r.shown_seconds);
          if (got_r.preset_minutes != want_r.preset_minutes)
            report_mismatch("preset_minutes", got_r.preset_minutes, want_r.preset_minutes);
          if (got_r.cooling_left != want_r.cooling_left)
            report_mismatch("cooling_left", got_r.cooling_left, want_r.cooling_left);
          if (got_r.timer_done != want_r.timer_done)
            report_mismatch("timer_done", got_r.timer_done, want_r.timer_done);
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (!steady && $urandom_range(0, 9) == 0) out_gap = $urandom_range(1, 5);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("button_countdown_fan_timer regression: fail");
      $finish;
    end
  end

  task automatic push_beat(logic act, logic level);
    item_t it;
    it.action       = act;
    it.button_level = level;
    pending_beats.push_back(it);
    beats_queued++;
  endtask

  task automatic press_button(int hold);
    repeat (hold) push_beat(1'b0, 1'b0);
    repeat ($urandom_range(3, 6)) push_beat(1'b0, 1'b1);
  endtask

  function automatic int span(logic [CFG_DATA_W-1:0] ticks);
    return (ticks > 60) ? 60 : int'(ticks);
  endfunction

  task automatic settle();
    while (results_seen != beats_queued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // called at a rising edge with the timer idle
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_MIN_PRESS: min_cfg   = val;
      REG_SHORT:     short_cfg = val;
      REG_LONG:      long_cfg  = val;
      REG_SET_IDLE:  idle_cfg  = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_timing(logic [15:0] mn, logic [15:0] sh, logic [15:0] lg,
                            logic [15:0] idle);
    write_reg(REG_MIN_PRESS, mn);
    write_reg(REG_SHORT, sh);
    write_reg(REG_LONG, lg);
    write_reg(REG_SET_IDLE, idle);
  endtask

  // mostly whole presses and runs of seconds, with some pin noise
  task automatic run_random(int n);
    int stop_at, kind, len;
    stop_at = beats_queued + n;
    while (beats_queued < stop_at) begin
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        press_button($urandom_range(1, span(short_cfg) + 2));
      end else if (kind < 50) begin
        press_button($urandom_range(span(long_cfg), span(long_cfg) + 12));
      end else if (kind < 75) begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(120, 260) : $urandom_range(1, 80);
        repeat (len) push_beat(1'b1, 1'($urandom_range(0, 1)));
      end else if (kind < 88) begin
        repeat ($urandom_range(1, span(idle_cfg) + 4)) push_beat(1'b0, 1'b1);
      end else begin
        repeat ($urandom_range(1, 8)) push_beat(1'b0, 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    reset_timer_model();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset timing: idle second ticks, a glitch, start, two seconds, stop
    push_beat(1'b1, 1'b0);
    push_beat(1'b1, 1'b1);
    push_beat(1'b0, 1'b0);
    push_beat(1'b0, 1'b1);
    press_button(3);
    push_beat(1'b1, 1'b1);
    push_beat(1'b1, 1'b0);
    press_button(3);
    settle();

    set_timing(16'd2, 16'd12, 16'd20, 16'd40);
    run_random(350);
    settle();
    run_random(350);
    settle();

    set_timing(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    write_reg(SPARE_IDX, 16'hFFFF);
    run_random(300);
    settle();

    set_timing(16'hFFFF, 16'd1, 16'd1, 16'd1);
    run_random(200);
    settle();

    steady = 1'b1;
    set_timing(16'd1, 16'd8, 16'd14, 16'd25);
    run_random(400);
    settle();

    if (err_count == 0) begin
      $display("button_countdown_fan_timer regression: pass");
    end else begin
      $display("button_countdown_fan_timer regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/bcft_pkg.sv
rtl/bcft_core.sv
rtl/button_countdown_fan_timer.sv
rtl/bcft_checker.sv
test/tb_button_countdown_fan_timer.sv
